// ===== hdl/tlvd_pkg.sv =====
package tlvd_pkg;

  // size of the type name table and of the header fields
  localparam int NUM_NAMES    = 6;
  localparam int TYPE_ENTRIES = 6;
  localparam int NAME_W       = 32;
  localparam int LEN_W        = 32;
  localparam int TYPE_IDX_W   = 3;
  localparam int SIZE_W       = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int BYTE_W       = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_IDX = CFG_IDX_W'(NUM_NAMES);

  typedef enum logic {
    OP_BYTE  = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    EV_HEADER  = 2'd0,
    EV_PAYLOAD = 2'd1,
    EV_EMPTY   = 2'd2,
    EV_ERROR   = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    ERR_NONE    = 2'd0,
    ERR_TYPE    = 2'd1,
    ERR_IGNORED = 2'd2,
    ERR_RSVD    = 2'd3
  } err_t;

  typedef logic [NUM_NAMES-1:0][NAME_W-1:0] name_tbl_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] byte_value;
  } in_item_t;

  typedef struct packed {
    event_t                event_res;
    logic [TYPE_IDX_W-1:0] type_id;
    logic [LEN_W-1:0]      msg_length;
    logic [BYTE_W-1:0]     payload_byte;
    logic                  last;
    err_t                  error_code;
  } out_item_t;

  // type lookup result
  typedef struct packed {
    logic                  found;
    logic [TYPE_IDX_W-1:0] index;
  } match_t;

endpackage

// ===== hdl/tlvd_cfg_regs.sv =====
module tlvd_cfg_regs
  import tlvd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [NAME_W-1:0]    cfg_data,
  output name_tbl_t            names,
  output logic [SIZE_W-1:0]    table_size
);

  name_tbl_t          names_r, names_nxt;
  logic [SIZE_W-1:0]  size_r, size_nxt;

  assign cfg_ready = 1'b1;

  // decode the register index of a write beat
  always_comb begin
    names_nxt = names_r;
    size_nxt  = size_r;
    if (cfg_valid) begin
      for (int i = 0; i < NUM_NAMES; i++) begin
        if (cfg_index == CFG_IDX_W'(i)) begin
          names_nxt[i] = cfg_data;
        end
      end
      if (cfg_index == CFG_SIZE_IDX) begin
        size_nxt = cfg_data[SIZE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      names_r <= '0;
      size_r  <= '0;
    end else begin
      names_r <= names_nxt;
      size_r  <= size_nxt;
    end
  end

  assign names      = names_r;
  assign table_size = size_r;

endmodule

// ===== hdl/tlvd_type_match.sv =====
module tlvd_type_match
  import tlvd_pkg::*;
(
  input  logic [NAME_W-1:0] type_word,
  input  name_tbl_t         names,
  input  logic [SIZE_W-1:0] table_size,
  output match_t            match
);

  logic [SIZE_W-1:0] used;

  // entries beyond the table are never searched
  assign used = (table_size > SIZE_W'(TYPE_ENTRIES)) ? SIZE_W'(TYPE_ENTRIES) : table_size;

  // parallel compare, lowest matching entry wins
  always_comb begin
    match = '0;
    for (int i = TYPE_ENTRIES - 1; i >= 0; i--) begin
      if ((SIZE_W'(i) < used) && (names[i] == type_word)) begin
        match.found = 1'b1;
        match.index = TYPE_IDX_W'(i);
      end
    end
  end

endmodule

// ===== hdl/tlvd_parser.sv =====
module tlvd_parser
  import tlvd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item,
  output logic [NAME_W-1:0] type_word,
  input  match_t            match
);

  typedef enum logic [1:0] {
    ST_TYPE = 2'd0,
    ST_LEN  = 2'd1,
    ST_DATA = 2'd2,
    ST_ERR  = 2'd3
  } stage_t;

  localparam logic [1:0] HDR_LAST = 2'd3;

  logic                  in_vld_r;
  in_item_t              in_item_r;
  logic                  out_vld_r;
  out_item_t             out_item_r;

  stage_t                stage_r, stage_nxt;
  logic [1:0]            hdr_cnt_r, hdr_cnt_nxt;
  logic [NAME_W-9:0]     type_shift_r, type_shift_nxt;
  logic [TYPE_IDX_W-1:0] type_idx_r, type_idx_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic [LEN_W-1:0]      remain_r, remain_nxt;
  out_item_t             res;

  logic                  is_clear;
  logic                  adv;
  logic [LEN_W-1:0]      len_shifted;

  // a clear beat leaves no result, so it never waits on the output
  assign is_clear = (in_item_r.op == OP_CLEAR);
  assign adv      = in_vld_r && (is_clear || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  assign type_word   = {type_shift_r, in_item_r.byte_value};
  assign len_shifted = {len_r[LEN_W-9:0], in_item_r.byte_value};

  // next parser state and result for the registered beat
  always_comb begin
    stage_nxt      = stage_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    type_shift_nxt = type_shift_r;
    type_idx_nxt   = type_idx_r;
    len_nxt        = len_r;
    remain_nxt     = remain_r;
    res            = '0;
    res.event_res  = EV_HEADER;
    res.error_code = ERR_NONE;
    if (is_clear) begin
      stage_nxt      = ST_TYPE;
      hdr_cnt_nxt    = '0;
      type_shift_nxt = '0;
      type_idx_nxt   = '0;
      len_nxt        = '0;
      remain_nxt     = '0;
    end else begin
      case (stage_r)
        ST_TYPE: begin
          type_shift_nxt = type_word[NAME_W-9:0];
          if (hdr_cnt_r != HDR_LAST) begin
            hdr_cnt_nxt = hdr_cnt_r + 2'd1;
          end else begin
            hdr_cnt_nxt = '0;
            if (match.found) begin
              type_idx_nxt = match.index;
              stage_nxt    = ST_LEN;
              len_nxt      = '0;
              res.type_id  = match.index;
            end else begin
              stage_nxt      = ST_ERR;
              res.event_res  = EV_ERROR;
              res.error_code = ERR_TYPE;
            end
          end
        end
        ST_LEN: begin
          len_nxt     = len_shifted;
          res.type_id = type_idx_r;
          if (hdr_cnt_r != HDR_LAST) begin
            hdr_cnt_nxt = hdr_cnt_r + 2'd1;
          end else begin
            hdr_cnt_nxt = '0;
            remain_nxt  = len_shifted;
            if (len_shifted == '0) begin
              // empty message ends right here
              stage_nxt      = ST_TYPE;
              type_shift_nxt = '0;
              res.event_res  = EV_EMPTY;
            end else begin
              stage_nxt      = ST_DATA;
              res.msg_length = len_shifted;
            end
          end
        end
        ST_DATA: begin
          remain_nxt       = remain_r - LEN_W'(1);
          res.event_res    = EV_PAYLOAD;
          res.type_id      = type_idx_r;
          res.msg_length   = len_r;
          res.payload_byte = in_item_r.byte_value;
          res.last         = (remain_r == LEN_W'(1));
          if (remain_r == LEN_W'(1)) begin
            stage_nxt      = ST_TYPE;
            type_shift_nxt = '0;
          end
        end
        default: begin
          res.event_res  = EV_ERROR;
          res.type_id    = type_idx_r;
          res.msg_length = len_r;
          res.error_code = ERR_IGNORED;
        end
      endcase
    end
  end

  // input register, parser state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      in_item_r    <= '0;
      out_vld_r    <= 1'b0;
      out_item_r   <= '0;
      stage_r      <= ST_TYPE;
      hdr_cnt_r    <= '0;
      type_shift_r <= '0;
      type_idx_r   <= '0;
      len_r        <= '0;
      remain_r     <= '0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (in_ready && in_valid) begin
        in_item_r <= in_item;
      end
      if (adv) begin
        stage_r      <= stage_nxt;
        hdr_cnt_r    <= hdr_cnt_nxt;
        type_shift_r <= type_shift_nxt;
        type_idx_r   <= type_idx_nxt;
        len_r        <= len_nxt;
        remain_r     <= remain_nxt;
      end
      if (adv && !is_clear) begin
        out_vld_r  <= 1'b1;
        out_item_r <= res;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule

// ===== hdl/tlv_message_deframer_unit.sv =====
// TLV message deframer
// in channel: one beat per stream byte (op = byte) or a clear beat (op = clear)
//   that drops the parser back to waiting for a type word; clear gives no result.
// out channel: one result beat per stream byte, carrying the event, the matched
//   type index, the message length, the payload byte, last and an error code.
// cfg channel: index 0..5 writes a four-character type name, index 6 the number
//   of names in use; always ready. The user must write it only while no byte
//   is in flight; the block does not enforce this. A byte passes the input
//   register, then the result register, before its result shows at out_valid.
// Throughput: one byte per cycle unless the receiver stalls; the type compare
//   against all names runs in parallel and the length counter steps once per byte.
// A finished result waits in the result register while the next byte sits in
//   the input register; when the receiver stalls both fill and in_ready drops
//   until out_ready returns, unless the waiting beat is a clear.
// Reset: parser waits for a type word, names and table size read zero, so
//   every type word is an error until the table is written.
module tlv_message_deframer_unit
  import tlvd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [NAME_W-1:0]    cfg_data
);

  name_tbl_t          names;
  logic [SIZE_W-1:0]  table_size;
  logic [NAME_W-1:0]  type_word;
  match_t             match;

  tlvd_cfg_regs u_cfg_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .names      (names),
    .table_size (table_size)
  );

  tlvd_type_match u_type_match (
    .type_word  (type_word),
    .names      (names),
    .table_size (table_size),
    .match      (match)
  );

  tlvd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .type_word (type_word),
    .match     (match)
  );

  // payload and last only travel with payload events
  a_payload_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.event_res != EV_PAYLOAD)
      |-> (out_item.payload_byte == '0) && !out_item.last)
    else $error("payload fields set on a non-payload result");

  // error code only with error events
  a_error_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.error_code != ERR_NONE) |-> (out_item.event_res == EV_ERROR))
    else $error("error code on a non-error result");

  // a match never points past the names in use
  a_match_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    match.found |-> (SIZE_W'(match.index) < table_size)
                    && (match.index < TYPE_IDX_W'(TYPE_ENTRIES)))
    else $error("type match outside the table");

  // an empty message reports zero length
  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.event_res == EV_EMPTY) |-> (out_item.msg_length == '0))
    else $error("empty message with nonzero length");

endmodule
